### rtl/oct2v_pkg.sv
// ---------------------------------------------------------------------------
// oct2v_pkg
// Shared widths, constants and helpers for the octahedral direction decoder.
// ---------------------------------------------------------------------------
package oct2v_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS   = 15;

    localparam int CIN_W  = COORD_FRAC_BITS + 1;       // coordinate port width
    localparam int C_W    = COORD_FRAC_BITS + 2;       // signed remapped component
    localparam int MAG_W  = COORD_FRAC_BITS + 1;       // component magnitude
    localparam int SQ_W   = 2 * MAG_W;                 // one square
    localparam int ROOT_W = MAG_W + 1;                 // vector length
    localparam int SUM_W  = 2 * ROOT_W;                // sum of squares
    localparam int NUM_W  = MAG_W + OUT_FRAC_BITS + 1; // divider numerator
    localparam int QUO_W  = OUT_FRAC_BITS + 2;         // quotient
    localparam int CMP_W  = NUM_W + 1;                 // divider compare width
    localparam int OUT_W  = OUT_FRAC_BITS + 1;         // output component

    localparam logic [C_W-1:0] ONE_IN = C_W'(1) << COORD_FRAC_BITS;
    localparam int EPS_VAL = ((2 ** COORD_FRAC_BITS) + 5000) / 10000;
    localparam logic [C_W-1:0] EPS_IN = C_W'(EPS_VAL);
    localparam logic [OUT_W-1:0] OUT_MAX = (OUT_W'(1) << OUT_FRAC_BITS) - OUT_W'(1);
    localparam logic [OUT_W-1:0] OUT_MIN = OUT_W'(1) << OUT_FRAC_BITS;

    // pipeline: input, fold, square, sum, root steps, numerator, quotient steps, output
    localparam int PIPE_LEN = 6 + ROOT_W + QUO_W;

    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] REG_FULL_SPHERE = 2'd0;

    // saturate and re-sign one quotient
    function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [QUO_W-1:0] quo);
        logic [OUT_W-1:0] res;
        if (!neg) begin
            res = (quo > QUO_W'(OUT_MAX)) ? OUT_MAX : quo[OUT_W-1:0];
        end else begin
            res = (quo > QUO_W'(OUT_MIN)) ? OUT_MIN : OUT_W'(-quo);
        end
        return res;
    endfunction

endpackage

### rtl/oct2v_isqrt.sv
// ---------------------------------------------------------------------------
// oct2v_isqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module oct2v_isqrt (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [oct2v_pkg::SUM_W-1:0]      i_rad,
    output logic [oct2v_pkg::ROOT_W-1:0]     o_root
);

    localparam int RW = oct2v_pkg::ROOT_W;
    localparam int SW = oct2v_pkg::SUM_W;

    logic [SW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam int BIT = RW - 1 - k;
        logic [SW-1:0] w_rem_in;
        logic [RW-1:0] w_root_in;
        logic [SW-1:0] w_trial;
        logic [SW-1:0] n_rem;
        logic [RW-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_rad;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
        end

        assign w_trial = (SW'(w_root_in) << (BIT + 1)) | (SW'(1) << (2 * BIT));

        always_comb begin
            if (w_rem_in >= w_trial) begin
                n_rem  = w_rem_in - w_trial;
                n_root = w_root_in | (RW'(1) << BIT);
            end else begin
                n_rem  = w_rem_in;
                n_root = w_root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

### rtl/oct2v_div.sv
// ---------------------------------------------------------------------------
// oct2v_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module oct2v_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [oct2v_pkg::NUM_W-1:0]      i_num,
    input  logic [oct2v_pkg::ROOT_W-1:0]     i_den,
    output logic [oct2v_pkg::QUO_W-1:0]      o_quo
);

    localparam int QW = oct2v_pkg::QUO_W;
    localparam int NW = oct2v_pkg::NUM_W;
    localparam int DW = oct2v_pkg::ROOT_W;
    localparam int CW = oct2v_pkg::CMP_W;

    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int BIT = QW - 1 - k;
        logic [NW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_quo_in;
        logic [CW-1:0] w_trial;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_trial = CW'(w_den_in) << BIT;

        always_comb begin
            if (CW'(w_rem_in) >= w_trial) begin
                n_rem = NW'(CW'(w_rem_in) - w_trial);
                n_quo = w_quo_in | (QW'(1) << BIT);
            end else begin
                n_rem = w_rem_in;
                n_quo = w_quo_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den_in;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

### rtl/octahedral_to_unit_vector.sv
// ---------------------------------------------------------------------------
// octahedral_to_unit_vector
// Decodes an octahedral map coordinate pair into a normalised direction.
// ---------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one word (u, v), unsigned
// Q1.16, values above 1.0 are clamped. Output channel: o_out_valid /
// i_out_stall carry one word (x, y, z), signed Q1.15, +1.0 saturated.
// A word moves on a clock edge where valid is high and stall is low.
// Throughput is one word per cycle while the receiver does not stall.
// The length comes from an 18-stage square root, and the three components
// go through 17-stage dividers sharing that length.
// The whole pipeline advances when the output register is empty or taken;
// o_in_stall rises only while a finished word waits and the receiver stalls.
// Bubbles in the pipeline still move forward under a stall only once the
// output is free.
// Reset (synchronous, i_rst_n low) empties the pipeline and sets
// full_sphere to 1. The APB register full_sphere (byte address 0) selects
// full octahedral (1) or hemi-octahedral (0) mapping; write it only while
// the block is idle.
// ---------------------------------------------------------------------------
module octahedral_to_unit_vector (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [oct2v_pkg::CIN_W-1:0]           i_coord_u,
    input  logic [oct2v_pkg::CIN_W-1:0]           i_coord_v,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [oct2v_pkg::OUT_W-1:0]    o_dir_x,
    output logic signed [oct2v_pkg::OUT_W-1:0]    o_dir_y,
    output logic signed [oct2v_pkg::OUT_W-1:0]    o_dir_z,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [oct2v_pkg::ADDR_W-1:0]          paddr,
    input  logic [oct2v_pkg::DATA_W-1:0]          pwdata,
    output logic [oct2v_pkg::DATA_W-1:0]          prdata,
    output logic                                  pready
);

    localparam int C_W    = oct2v_pkg::C_W;
    localparam int MAG_W  = oct2v_pkg::MAG_W;
    localparam int SQ_W   = oct2v_pkg::SQ_W;
    localparam int SUM_W  = oct2v_pkg::SUM_W;
    localparam int ROOT_W = oct2v_pkg::ROOT_W;
    localparam int NUM_W  = oct2v_pkg::NUM_W;
    localparam int QUO_W  = oct2v_pkg::QUO_W;
    localparam int OUT_W  = oct2v_pkg::OUT_W;
    localparam int PIPE   = oct2v_pkg::PIPE_LEN;
    localparam int CIN_W  = oct2v_pkg::CIN_W;

    typedef logic [2:0][MAG_W-1:0] t_mags;

    // ---- configuration ----
    logic r_full_sphere;

    assign pready = 1'b1;
    assign prdata = oct2v_pkg::DATA_W'(r_full_sphere);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_sphere <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr == oct2v_pkg::REG_FULL_SPHERE) begin
            r_full_sphere <= pwdata[0];
        end
    end

    // ---- pipeline control ----
    logic [PIPE-1:0] r_vld;
    logic            w_en;

    assign w_en        = !r_vld[PIPE-1] || !i_out_stall;
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_vld[PIPE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE-2:0], i_in_valid};
        end
    end

    // ---- stage A: clamp and remap to -1..1 ----
    logic [C_W-1:0] r_cx, r_cz;
    logic [CIN_W-1:0] w_mu, w_mv;

    assign w_mu = (i_coord_u > CIN_W'(oct2v_pkg::ONE_IN)) ? CIN_W'(oct2v_pkg::ONE_IN) : i_coord_u;
    assign w_mv = (i_coord_v > CIN_W'(oct2v_pkg::ONE_IN)) ? CIN_W'(oct2v_pkg::ONE_IN) : i_coord_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx <= {w_mu, 1'b0} - oct2v_pkg::ONE_IN;
            r_cz <= {w_mv, 1'b0} - oct2v_pkg::ONE_IN;
        end
    end

    // ---- stage B: hemisphere rotation, y, lower fold ----
    logic [C_W:0]     w_sum, w_dif;
    logic [C_W-1:0]   w_a, w_b, w_y, w_ye;
    logic [MAG_W-1:0] w_abs_a, w_abs_b;
    t_mags            n_mag;
    logic [2:0]       n_sgn;
    t_mags            r_mag_b;
    logic [2:0]       r_sgn_b;

    always_comb begin
        w_sum = {r_cx[C_W-1], r_cx} + {r_cz[C_W-1], r_cz};
        w_dif = {r_cx[C_W-1], r_cx} - {r_cz[C_W-1], r_cz};
        if (r_full_sphere) begin
            w_a = r_cx;
            w_b = r_cz;
        end else begin
            // sum and difference are always even
            w_a = w_sum[C_W:1];
            w_b = w_dif[C_W:1];
        end
        w_abs_a = w_a[C_W-1] ? MAG_W'(-w_a) : MAG_W'(w_a);
        w_abs_b = w_b[C_W-1] ? MAG_W'(-w_b) : MAG_W'(w_b);
        w_y  = oct2v_pkg::ONE_IN - C_W'(w_abs_a) - C_W'(w_abs_b);
        w_ye = w_y + oct2v_pkg::EPS_IN;
        if (r_full_sphere && w_y[C_W-1]) begin
            n_mag[0] = MAG_W'(oct2v_pkg::ONE_IN) - w_abs_b;
            n_mag[2] = MAG_W'(oct2v_pkg::ONE_IN) - w_abs_a;
        end else begin
            n_mag[0] = w_abs_a;
            n_mag[2] = w_abs_b;
        end
        n_sgn[0] = w_a[C_W-1];
        n_sgn[2] = w_b[C_W-1];
        n_sgn[1] = w_ye[C_W-1];
        n_mag[1] = w_ye[C_W-1] ? MAG_W'(-w_ye) : MAG_W'(w_ye);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag_b <= n_mag;
            r_sgn_b <= n_sgn;
        end
    end

    // ---- stage C: squares ----
    logic [SQ_W-1:0] r_sq [3];
    t_mags           r_mag_c;
    logic [2:0]      r_sgn_c;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SQ_W'(r_mag_b[i]) * SQ_W'(r_mag_b[i]);
            end
            r_mag_c <= r_mag_b;
            r_sgn_c <= r_sgn_b;
        end
    end

    // ---- stage D: sum of squares ----
    logic [SUM_W-1:0] r_ssum;
    t_mags            r_mag_d;
    logic [2:0]       r_sgn_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ssum  <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_mag_d <= r_mag_c;
            r_sgn_d <= r_sgn_c;
        end
    end

    // ---- square root, components delayed alongside ----
    logic [ROOT_W-1:0] w_len;
    t_mags             r_mag_dly [ROOT_W];
    logic [2:0]        r_sgn_dly [ROOT_W];

    oct2v_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_ssum),
        .o_root (w_len)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag_dly[0] <= r_mag_d;
            r_sgn_dly[0] <= r_sgn_d;
            for (int i = 1; i < ROOT_W; i++) begin
                r_mag_dly[i] <= r_mag_dly[i-1];
                r_sgn_dly[i] <= r_sgn_dly[i-1];
            end
        end
    end

    // ---- stage E: rounded numerators ----
    logic [NUM_W-1:0]  r_num [3];
    logic [ROOT_W-1:0] r_den;
    logic [2:0]        r_sgn_e;
    logic              r_zero_e;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= (NUM_W'(r_mag_dly[ROOT_W-1][i]) << oct2v_pkg::OUT_FRAC_BITS)
                            + NUM_W'(w_len >> 1);
            end
            r_den    <= w_len;
            r_sgn_e  <= r_sgn_dly[ROOT_W-1];
            r_zero_e <= (w_len == '0);
        end
    end

    // ---- dividers ----
    logic [QUO_W-1:0] w_quo [3];
    logic [2:0]       r_sgn_q  [QUO_W];
    logic             r_zero_q [QUO_W];

    for (genvar c = 0; c < 3; c++) begin : g_lane
        oct2v_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_num[c]),
            .i_den (r_den),
            .o_quo (w_quo[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sgn_q[0]  <= r_sgn_e;
            r_zero_q[0] <= r_zero_e;
            for (int i = 1; i < QUO_W; i++) begin
                r_sgn_q[i]  <= r_sgn_q[i-1];
                r_zero_q[i] <= r_zero_q[i-1];
            end
        end
    end

    // ---- output register ----
    logic [OUT_W-1:0] r_out [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_zero_q[QUO_W-1]) begin
                r_out[0] <= '0;
                r_out[1] <= oct2v_pkg::OUT_MAX;
                r_out[2] <= '0;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_out[i] <= oct2v_pkg::sat_out(r_sgn_q[QUO_W-1][i], w_quo[i]);
                end
            end
        end
    end

    assign o_dir_x = r_out[0];
    assign o_dir_y = r_out[1];
    assign o_dir_z = r_out[2];

endmodule

### rtl/oct2v_checker.sv
// ---------------------------------------------------------------------------
// oct2v_checker
// Port-level checks for the octahedral direction decoder.
// ---------------------------------------------------------------------------
module oct2v_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_stall,
    input  logic [oct2v_pkg::CIN_W-1:0]           i_coord_u,
    input  logic [oct2v_pkg::CIN_W-1:0]           i_coord_v,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    input  logic signed [oct2v_pkg::OUT_W-1:0]    o_dir_x,
    input  logic signed [oct2v_pkg::OUT_W-1:0]    o_dir_y,
    input  logic signed [oct2v_pkg::OUT_W-1:0]    o_dir_z,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [oct2v_pkg::ADDR_W-1:0]          paddr,
    input  logic [oct2v_pkg::DATA_W-1:0]          pwdata,
    input  logic [oct2v_pkg::DATA_W-1:0]          prdata,
    input  logic                                  pready
);

    // no word can appear right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input is held back only by a waiting, stalled output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_dir_x) && $stable(o_dir_y) && $stable(o_dir_z)))
        else $error("stalled output word changed");

    // a unit vector is never all zero: with x and z at zero, y is nonzero
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dir_x == '0 && o_dir_z == '0) |-> (o_dir_y != '0))
        else $error("output vector is zero");

endmodule

bind octahedral_to_unit_vector oct2v_checker u_oct2v_checker (.*);

### tb/tb_octahedral_to_unit_vector.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_octahedral_to_unit_vector
// Self-checking bench for the octahedral direction decoder. Coordinate words
// go in under random idling and stalls; each direction word is checked
// against an in-bench fixed-point model, in both mapping modes.
// ---------------------------------------------------------------------------
module tb_octahedral_to_unit_vector;

    localparam int CIN_W           = oct2v_pkg::CIN_W;
    localparam int OUT_W           = oct2v_pkg::OUT_W;
    localparam int ADDR_W          = oct2v_pkg::ADDR_W;
    localparam int DATA_W          = oct2v_pkg::DATA_W;
    localparam int COORD_FRAC_BITS = oct2v_pkg::COORD_FRAC_BITS;
    localparam int OUT_FRAC_BITS   = oct2v_pkg::OUT_FRAC_BITS;
    localparam int PIPE_LEN        = oct2v_pkg::PIPE_LEN;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
    } t_dir;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [CIN_W-1:0]     i_coord_u = '0;
    logic [CIN_W-1:0]     i_coord_v = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [OUT_W-1:0] o_dir_x, o_dir_y, o_dir_z;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    t_dir   dir_q[$];
    bit     sphere_mode;
    int     idle_pct;
    int     stall_pct;
    int     n_fail;

    octahedral_to_unit_vector u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint isqrt(longint s);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= s) r += 64'sd1 << b;
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] norm_comp(longint c, longint len);
        longint mag, q, r, top;
        top = 64'sd1 << OUT_FRAC_BITS;
        mag = c < 0 ? -c : c;
        q = ((mag << OUT_FRAC_BITS) + (len >> 1)) / len;
        if (c >= 0) r = q > top - 1 ? top - 1 : q;
        else r = q > top ? -top : -q;
        return r[OUT_W-1:0];
    endfunction

    function automatic t_dir decode_dir(logic [CIN_W-1:0] u, logic [CIN_W-1:0] v);
        longint one, cu, cv, cx, cz, a, b, x, y, z, len, ax, az;
        t_dir d;
        one = 64'sd1 << COORD_FRAC_BITS;
        cu = u > one ? one : u;
        cv = v > one ? one : v;
        cx = 2 * cu - one;
        cz = 2 * cv - one;
        if (!sphere_mode) begin
            a = (cx + cz) / 2;
            b = (cx - cz) / 2;
            cx = a;
            cz = b;
        end
        ax = cx < 0 ? -cx : cx;
        az = cz < 0 ? -cz : cz;
        y = one - ax - az;
        x = cx;
        z = cz;
        if (sphere_mode && y < 0) begin
            x = cx >= 0 ? one - az : -(one - az);
            z = cz >= 0 ? one - ax : -(one - ax);
        end
        y += oct2v_pkg::EPS_VAL;
        len = isqrt(x * x + y * y + z * z);
        if (len == 0) begin
            d.x = '0;
            d.y = oct2v_pkg::OUT_MAX;
            d.z = '0;
        end else begin
            d.x = norm_comp(x, len);
            d.y = norm_comp(y, len);
            d.z = norm_comp(z, len);
        end
        return d;
    endfunction

    // receiver: random stall, check every accepted word
    always @(posedge i_clk) begin
        t_dir exp_d;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (dir_q.size() == 0) begin
                $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                         o_dir_x, o_dir_y, o_dir_z);
                n_fail++;
            end else begin
                exp_d = dir_q.pop_front();
                if (exp_d.x !== o_dir_x || exp_d.y !== o_dir_y || exp_d.z !== o_dir_z) begin
                    $display("%0t: exp (%0d,%0d,%0d) got (%0d,%0d,%0d)", $time,
                             $signed(exp_d.x), $signed(exp_d.y), $signed(exp_d.z),
                             o_dir_x, o_dir_y, o_dir_z);
                    n_fail++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // valid is left high after the word; the next idle gap or drain drops it
    task automatic send_word(logic [CIN_W-1:0] u, logic [CIN_W-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_coord_u <= u;
        i_coord_v <= v;
        dir_q = {dir_q, decode_dir(u, v)};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (dir_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LEN + 4) @(posedge i_clk);
    endtask

    task automatic write_mode(bit full);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= oct2v_pkg::REG_FULL_SPHERE;
        pwdata <= {$urandom} & ~32'd1 | full;   // upper bits must be ignored
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sphere_mode = full;
        @(posedge i_clk);
    endtask

    function automatic logic [CIN_W-1:0] rand_coord();
        case ($urandom_range(9))
            0: return CIN_W'($urandom_range(65536, 131071));   // clamped
            1: return CIN_W'(65536);
            2: return '0;
            3: return CIN_W'(32768 + $urandom_range(8) - 4);
            default: return CIN_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic test_corners();
        logic [CIN_W-1:0] pts[6] = '{0, 1, 32767, 32768, 65536, 131071};
        foreach (pts[i])
            foreach (pts[j])
                if ((i * 6 + j) % 3 != 2 || i == j) send_word(pts[i], pts[j]);
        send_word(CIN_W'(98304), CIN_W'(16384));
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            case ((k * 4) / n)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            send_word(rand_coord(), rand_coord());
            // hold off once until the pipe is empty
            if (k == n / 2) begin
                i_in_valid <= 1'b0;
                while (dir_q.size() != 0) @(posedge i_clk);
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        n_fail = 0;
        sphere_mode = 1'b1;
        idle_pct = 0;
        stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();            // reset value: full sphere
        test_random(200);
        drain();
        write_mode(1'b0);
        test_corners();
        test_random(200);
        drain();
        write_mode(1'b1);
        test_random(150);
        drain();
        write_mode(1'b0);
        test_random(150);
        drain();
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/oct2v_pkg.sv
rtl/oct2v_isqrt.sv
rtl/oct2v_div.sv
rtl/octahedral_to_unit_vector.sv
rtl/oct2v_checker.sv
tb/tb_octahedral_to_unit_vector.sv
